// File: sv/quote_aware_space_stripper_core_defines.svh
// ----------------------------------------------------------------------------
// quote_aware_space_stripper_core_defines
// assertion macros used by the stripper rtl
// ----------------------------------------------------------------------------
`ifndef QUOTE_AWARE_SPACE_STRIPPER_CORE_DEFINES_SVH
`define QUOTE_AWARE_SPACE_STRIPPER_CORE_DEFINES_SVH

// same-cycle implication, disabled during reset
`define QASS_ASSERT_NOW(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication, disabled during reset
`define QASS_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: sv/qass_pkg.sv
// ----------------------------------------------------------------------------
// qass_pkg
// character codes and result type for the quote-aware space stripper
// ----------------------------------------------------------------------------
package qass_pkg;

	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_BLANK = 8'h20;

	typedef struct packed {
		logic [7:0] ch;
		logic       keep;
		logic       err;
		logic       last;
	} result_t;

endpackage

// File: sv/quote_aware_space_stripper_core.sv
// ----------------------------------------------------------------------------
// quote_aware_space_stripper_core
// strips blanks outside quoted strings, flags separated same-kind quotes
// ----------------------------------------------------------------------------
// usage:
//   input channel in_valid/in_ready carries one byte (in_char) and in_last.
//   output channel out_valid/out_ready returns one transaction per input:
//   out_char equal to the byte, keep, syntax_error and out_last.
//   out_valid rises once the byte has passed through the input register,
//   then the mode update and result logic into the result register; a full
//   result register with out_ready low holds the byte in the input register.
//   throughput is one byte per cycle while out_ready is high; the scan mode
//   register is the only loop and updates as each byte advances.
//   a stalled receiver holds the result register; the input register still
//   takes a byte when the result register is free or drains in that cycle,
//   so in_ready drops only when both stages are full and out_ready is low.
//   reset empties both stages and sets the scan mode to outside any string.
//   after a transaction with in_last the mode returns to outside any string.
// ----------------------------------------------------------------------------
`include "quote_aware_space_stripper_core_defines.svh"

module quote_aware_space_stripper_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_char,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_char,
	output logic       keep,
	output logic       syntax_error,
	output logic       out_last
);

	typedef enum logic [2:0] {
		NORMAL,
		IN_DQ,
		DQ_QUOTE,
		DQ_BLANK,
		IN_SQ,
		SQ_QUOTE,
		SQ_BLANK,
		ERR
	} mode_t;

	mode_t                mode_q;
	mode_t                mode_next;
	mode_t                out_mode;
	logic                 out_keep;
	logic                 v_s1;
	logic [7:0]           char_s1;
	logic                 last_s1;
	logic                 v_s2;
	qass_pkg::result_t    res_s2;
	qass_pkg::result_t    res_next;
	logic                 adv;
	logic                 is_dq;
	logic                 is_sq;
	logic                 is_blank;

	assign adv      = v_s1 && (!v_s2 || out_ready);
	assign in_ready = !v_s1 || adv;

	assign is_dq    = (char_s1 == qass_pkg::CH_DQ);
	assign is_sq    = (char_s1 == qass_pkg::CH_SQ);
	assign is_blank = (char_s1 == qass_pkg::CH_BLANK);

	// handling of a byte outside any string
	always_comb begin
		out_keep = !is_blank;
		if (is_dq) begin
			out_mode = IN_DQ;
		end else if (is_sq) begin
			out_mode = IN_SQ;
		end else begin
			out_mode = NORMAL;
		end
	end

	always_comb begin
		res_next.ch   = char_s1;
		res_next.keep = 1'b1;
		res_next.err  = 1'b0;
		res_next.last = last_s1;
		mode_next     = NORMAL;
		case (mode_q)
			NORMAL: begin
				res_next.keep = out_keep;
				mode_next     = out_mode;
			end
			IN_DQ: begin
				mode_next = is_dq ? DQ_QUOTE : IN_DQ;
			end
			IN_SQ: begin
				mode_next = is_sq ? SQ_QUOTE : IN_SQ;
			end
			DQ_QUOTE: begin
				if (is_dq) begin
					mode_next = IN_DQ;
				end else if (is_blank) begin
					res_next.keep = 1'b0;
					mode_next     = DQ_BLANK;
				end else begin
					res_next.keep = out_keep;
					mode_next     = out_mode;
				end
			end
			SQ_QUOTE: begin
				if (is_sq) begin
					mode_next = IN_SQ;
				end else if (is_blank) begin
					res_next.keep = 1'b0;
					mode_next     = SQ_BLANK;
				end else begin
					res_next.keep = out_keep;
					mode_next     = out_mode;
				end
			end
			DQ_BLANK: begin
				if (is_blank) begin
					res_next.keep = 1'b0;
					mode_next     = DQ_BLANK;
				end else if (is_dq) begin
					res_next.keep = 1'b0;
					res_next.err  = 1'b1;
					mode_next     = ERR;
				end else begin
					res_next.keep = out_keep;
					mode_next     = out_mode;
				end
			end
			SQ_BLANK: begin
				if (is_blank) begin
					res_next.keep = 1'b0;
					mode_next     = SQ_BLANK;
				end else if (is_sq) begin
					res_next.keep = 1'b0;
					res_next.err  = 1'b1;
					mode_next     = ERR;
				end else begin
					res_next.keep = out_keep;
					mode_next     = out_mode;
				end
			end
			ERR: begin
				res_next.keep = 1'b0;
				res_next.err  = 1'b1;
				mode_next     = ERR;
			end
			default: begin
				res_next.keep = out_keep;
				mode_next     = out_mode;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			v_s2   <= 1'b0;
			mode_q <= NORMAL;
		end else begin
			if (in_ready) begin
				v_s1 <= in_valid;
			end
			if (adv) begin
				v_s2   <= 1'b1;
				mode_q <= last_s1 ? NORMAL : mode_next;
			end else if (out_ready) begin
				v_s2 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			char_s1 <= in_char;
			last_s1 <= in_last;
		end
		if (adv) begin
			res_s2 <= res_next;
		end
	end

	assign out_valid    = v_s2;
	assign out_char     = res_s2.ch;
	assign keep         = res_s2.keep;
	assign syntax_error = res_s2.err;
	assign out_last     = res_s2.last;

	// flagged bytes are never kept
	`QASS_ASSERT_NOW(a_err_drops, clk, arst_n, v_s2 && res_s2.err, !res_s2.keep)
	// last transaction puts the scanner back outside any string
	`QASS_ASSERT_NEXT(a_last_resets, clk, arst_n, adv && last_s1, mode_q == NORMAL)
	// blank outside any string is dropped
	`QASS_ASSERT_NEXT(a_blank_drop, clk, arst_n,
		adv && (mode_q == NORMAL) && is_blank, !res_s2.keep)
	// pending error keeps the flag up
	`QASS_ASSERT_NEXT(a_err_held, clk, arst_n, adv && (mode_q == ERR), res_s2.err)
	// free result register means the input side never stalls
	`QASS_ASSERT_NOW(a_no_stall, clk, arst_n, !v_s2, in_ready)

endmodule
